/* rtl/core/lpcc_pkg.sv */
// Shared types and constants for the record payload CRC checker.
package lpcc_pkg;

    // Width of the length counters; lengths and length registers are taken in these low bits
    localparam int LENGTH_BITS = 20;

    localparam int TYPE_W     = 16;
    localparam int LEN_FIELD_W = 20;
    localparam int CRC_W      = 32;
    localparam int BYTE_W     = 8;

    localparam logic [CRC_W-1:0] CRC_ONES = '1;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;
    localparam logic [CFG_INDEX_W-1:0] CFG_INODE_TYPE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INODE_REQ_LEN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INODE_COV_LEN  = 2'd2;

    localparam logic [TYPE_W-1:0]      INODE_TYPE_RESET = 16'd1;
    localparam logic [LENGTH_BITS-1:0] INODE_REQ_RESET  = LENGTH_BITS'(128);
    localparam logic [LENGTH_BITS-1:0] INODE_COV_RESET  = LENGTH_BITS'(128);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic {
        OP_HEADER = 1'b0,
        OP_DATA   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        VERDICT_MATCH      = 2'd0,
        VERDICT_MISMATCH   = 2'd1,
        VERDICT_LENGTH_BAD = 2'd2
    } verdict_t;

    typedef enum logic {
        CMD_EMPTY = 1'b0,   // header with empty payload: report at once
        CMD_BYTE  = 1'b1    // one payload byte of an open record
    } cmd_kind_t;

    typedef struct packed {
        op_t                    op;
        logic [TYPE_W-1:0]      record_type;
        logic [LEN_FIELD_W-1:0] payload_length;
        logic [CRC_W-1:0]       expected_crc;
        logic [BYTE_W-1:0]      payload_byte;
    } in_item_t;

    typedef struct packed {
        logic     crc_matches;
        verdict_t verdict;
    } result_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              first;       // restart the CRC before this byte
        logic              update;      // byte is covered by the CRC
        logic              last;        // report after this byte
        logic              length_bad;
        logic [BYTE_W-1:0] data;
        logic [CRC_W-1:0]  expected;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_wr_t;

endpackage

/* rtl/core/leaf_payload_crc_check.sv */
// Top level of the record payload CRC checker: front end, command queue and CRC back end.
//
//   Channel   Ports                        Direction  Carries
//   s_        s_valid s_ready s_data       in         headers and payload bytes
//   m_        m_valid m_ready m_data       out        one verdict per record
//   cfg_      cfg_we cfg_index cfg_wdata   in         inode type and length settings
//
// One request per cycle is accepted while the command queue has room; the CRC unit does
// a full bytewise CRC-32 update per cycle, but holds a record's last byte while a verdict waits on m_.
// A verdict appears on m_ the cycle after its command leaves the queue (empty-payload
// header or last payload byte).
// Reset is synchronous on aresetn low; configuration returns to type 1, lengths 128.
// A stalled m_ side fills the four-entry queue, then s_ready drops.
module leaf_payload_crc_check (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [lpcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lpcc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lpcc_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lpcc_pkg::result_t                   m_data
);

    lpcc_pkg::q_wr_t q_wr;
    lpcc_pkg::cmd_t  q_cmd;
    lpcc_pkg::cmd_t  q_head;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    // Classify requests and keep per-record length bookkeeping
    lpcc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_wr      (q_wr),
        .q_cmd     (q_cmd),
        .q_full    (q_full)
    );

    // Hold commands so either side can stall on its own
    lpcc_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_wr.push),
        .push_data (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Advance the CRC and register verdicts
    lpcc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* rtl/core/lpcc_cmd_queue.sv */
// Short command queue that decouples the record front end from the CRC back end.
module lpcc_cmd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lpcc_pkg::cmd_t    push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output lpcc_pkg::cmd_t    head
);

    lpcc_pkg::cmd_t                      entry_reg [lpcc_pkg::QUEUE_DEPTH];
    logic [lpcc_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [lpcc_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [lpcc_pkg::QCNT_W-1:0]         count_reg, count_next;

    assign full  = (count_reg == lpcc_pkg::QCNT_W'(lpcc_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("command popped from an empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= lpcc_pkg::QCNT_W'(lpcc_pkg::QUEUE_DEPTH))
        else $error("queue fill count out of range");
`endif

endmodule

/* rtl/core/lpcc_front.sv */
// Front end: accepts requests, tracks record lengths and issues CRC commands.
module lpcc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [lpcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lpcc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lpcc_pkg::in_item_t                  s_data,
    output lpcc_pkg::q_wr_t                     q_wr,
    output lpcc_pkg::cmd_t                      q_cmd,
    input  logic                                q_full
);

    logic [lpcc_pkg::TYPE_W-1:0]      inode_type_reg;
    logic [lpcc_pkg::LENGTH_BITS-1:0] req_len_reg;
    logic [lpcc_pkg::LENGTH_BITS-1:0] cov_len_reg;

    logic [lpcc_pkg::LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [lpcc_pkg::LENGTH_BITS-1:0] cov_left_reg, cov_left_next;
    logic [lpcc_pkg::CRC_W-1:0]       expected_reg, expected_next;
    logic                             length_bad_reg, length_bad_next;
    logic                             open_reg, open_next;
    logic                             first_reg, first_next;

    logic                             accept;
    logic [lpcc_pkg::LENGTH_BITS-1:0] hdr_len;
    logic                             is_inode;
    logic [lpcc_pkg::LENGTH_BITS-1:0] cov_clip;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign hdr_len   = lpcc_pkg::LENGTH_BITS'(s_data.payload_length);
    assign is_inode  = (s_data.record_type == inode_type_reg);
    assign cov_clip  = (cov_len_reg < hdr_len) ? cov_len_reg : hdr_len;

    always_comb begin
        bytes_left_next = bytes_left_reg;
        cov_left_next   = cov_left_reg;
        expected_next   = expected_reg;
        length_bad_next = length_bad_reg;
        open_next       = open_reg;
        first_next      = first_reg;
        q_wr.full       = q_full;
        q_wr.push       = 1'b0;
        q_cmd.kind      = lpcc_pkg::CMD_BYTE;
        q_cmd.first     = first_reg;
        q_cmd.update    = (cov_left_reg != '0);
        q_cmd.last      = (bytes_left_reg == lpcc_pkg::LENGTH_BITS'(1));
        q_cmd.length_bad = length_bad_reg;
        q_cmd.data      = s_data.payload_byte;
        q_cmd.expected  = expected_reg;
        if (accept) begin
            if (s_data.op == lpcc_pkg::OP_HEADER) begin
                // Open a new record; any open one is dropped silently
                expected_next = s_data.expected_crc;
                if (hdr_len == '0) begin
                    open_next       = 1'b0;
                    bytes_left_next = '0;
                    cov_left_next   = '0;
                    length_bad_next = 1'b0;
                    q_wr.push       = 1'b1;
                    q_cmd.kind      = lpcc_pkg::CMD_EMPTY;
                    q_cmd.expected  = s_data.expected_crc;
                end else begin
                    open_next       = 1'b1;
                    first_next      = 1'b1;
                    bytes_left_next = hdr_len;
                    length_bad_next = is_inode && (hdr_len != req_len_reg);
                    cov_left_next   = is_inode ? cov_clip : hdr_len;
                end
            end else if (open_reg) begin
                q_wr.push       = 1'b1;
                first_next      = 1'b0;
                bytes_left_next = bytes_left_reg - 1'b1;
                if (cov_left_reg != '0) begin
                    cov_left_next = cov_left_reg - 1'b1;
                end
                if (bytes_left_reg == lpcc_pkg::LENGTH_BITS'(1)) begin
                    open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inode_type_reg <= lpcc_pkg::INODE_TYPE_RESET;
            req_len_reg    <= lpcc_pkg::INODE_REQ_RESET;
            cov_len_reg    <= lpcc_pkg::INODE_COV_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lpcc_pkg::CFG_INODE_TYPE: begin
                    inode_type_reg <= lpcc_pkg::TYPE_W'(cfg_wdata);
                end
                lpcc_pkg::CFG_INODE_REQ_LEN: begin
                    req_len_reg <= lpcc_pkg::LENGTH_BITS'(cfg_wdata);
                end
                lpcc_pkg::CFG_INODE_COV_LEN: begin
                    cov_len_reg <= lpcc_pkg::LENGTH_BITS'(cfg_wdata);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            cov_left_reg   <= '0;
            expected_reg   <= '0;
            length_bad_reg <= 1'b0;
            open_reg       <= 1'b0;
            first_reg      <= 1'b0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            cov_left_reg   <= cov_left_next;
            expected_reg   <= expected_next;
            length_bad_reg <= length_bad_next;
            open_reg       <= open_next;
            first_reg      <= first_next;
        end
    end

endmodule

/* rtl/core/lpcc_back.sv */
// Back end: runs the bytewise CRC-32 and holds the verdict for the result channel.
module lpcc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  lpcc_pkg::cmd_t       q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lpcc_pkg::result_t    m_data
);

    logic [lpcc_pkg::CRC_W-1:0] crc_reg, crc_next;
    logic                       m_valid_reg, m_valid_next;
    lpcc_pkg::result_t          m_data_reg, m_data_next;

    logic                       emits;
    logic                       out_free;
    logic [lpcc_pkg::CRC_W-1:0] crc_base;

    // Reflected CRC-32 over one byte, one polynomial step per bit
    function automatic logic [lpcc_pkg::CRC_W-1:0] crc_byte(
        input logic [lpcc_pkg::CRC_W-1:0]  crc_in,
        input logic [lpcc_pkg::BYTE_W-1:0] data
    );
        logic [lpcc_pkg::CRC_W-1:0] c;
        c = crc_in ^ lpcc_pkg::CRC_W'(data);
        for (int k = 0; k < lpcc_pkg::BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ lpcc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    assign emits    = (q_head.kind == lpcc_pkg::CMD_EMPTY) || q_head.last;
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = !q_empty && (!emits || out_free);
    assign crc_base = q_head.first ? lpcc_pkg::CRC_ONES : crc_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        crc_next     = crc_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (q_pop) begin
            if (q_head.kind == lpcc_pkg::CMD_EMPTY) begin
                // Empty payload checks against a CRC of zero
                m_valid_next = 1'b1;
                if (q_head.expected == '0) begin
                    m_data_next.crc_matches = 1'b1;
                    m_data_next.verdict     = lpcc_pkg::VERDICT_MATCH;
                end else begin
                    m_data_next.crc_matches = 1'b0;
                    m_data_next.verdict     = lpcc_pkg::VERDICT_MISMATCH;
                end
            end else begin
                crc_next = q_head.update ? crc_byte(crc_base, q_head.data) : crc_base;
                if (q_head.last) begin
                    m_valid_next = 1'b1;
                    if (q_head.length_bad) begin
                        m_data_next.crc_matches = 1'b0;
                        m_data_next.verdict     = lpcc_pkg::VERDICT_LENGTH_BAD;
                    end else if ((crc_next ^ lpcc_pkg::CRC_ONES) == q_head.expected) begin
                        m_data_next.crc_matches = 1'b1;
                        m_data_next.verdict     = lpcc_pkg::VERDICT_MATCH;
                    end else begin
                        m_data_next.crc_matches = 1'b0;
                        m_data_next.verdict     = lpcc_pkg::VERDICT_MISMATCH;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= lpcc_pkg::CRC_ONES;
            m_valid_reg <= 1'b0;
        end else begin
            crc_reg     <= crc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    a_verdict_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.crc_matches == (m_data_reg.verdict == lpcc_pkg::VERDICT_MATCH)))
        else $error("match flag disagrees with verdict");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the record payload CRC checker: directed table, then random records.
`timescale 1ns / 1ps

module testbench;
    import lpcc_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_GAP      = 5;
    // The queue can hold bytes that never produce a verdict, so let it empty
    // before touching the inode registers.
    localparam int HOLD_OFF     = QUEUE_DEPTH + 4;
    localparam int QUIET_LIMIT  = 2000;
    localparam int CHUNK        = 60;
    localparam int PRINT_CAP    = 40;

    typedef struct {
        in_item_t item;
        bit       typed;    // verdict read off by hand instead of predicted
        result_t  want;
    } stim_row_t;

    typedef struct {
        logic [CFG_DATA_W-1:0] type_word;
        logic [CFG_DATA_W-1:0] req_word;
        logic [CFG_DATA_W-1:0] cov_word;
        int                    requests;
    } rule_set_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    result_t                m_data;

    leaf_payload_crc_check dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Inode rule as the block should hold it; starts at the reset values.
    logic [TYPE_W-1:0]      inode_code = INODE_TYPE_RESET;
    logic [LENGTH_BITS-1:0] inode_req  = INODE_REQ_RESET;
    logic [LENGTH_BITS-1:0] inode_cov  = INODE_COV_RESET;

    // Record state mirrored from the block.
    logic [CRC_W-1:0]       crc_acc      = CRC_ONES;
    logic [LENGTH_BITS-1:0] bytes_to_go  = '0;
    logic [LENGTH_BITS-1:0] covered_left = '0;
    logic [CRC_W-1:0]       crc_on_file  = '0;
    bit                     length_wrong = 1'b0;
    bit                     rec_open     = 1'b0;

    result_t   verdicts_due[$];
    stim_row_t stim_rows[$];

    bit send_gaps_on   = 1'b0;
    bit take_stalls_on = 1'b0;
    int error_count      = 0;
    int requests_counted = 0;
    int records_started  = 0;
    int verdicts_seen    = 0;
    int rule_sets        = 1;
    int quiet_cycles     = 0;

    // Reflected CRC-32, one byte.
    function automatic logic [CRC_W-1:0] crc32_byte(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
        c ^= {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic result_t grade(bit len_err, logic [CRC_W-1:0] crc, logic [CRC_W-1:0] want);
        result_t r;
        if (len_err) begin
            r.crc_matches = 1'b0;
            r.verdict     = VERDICT_LENGTH_BAD;
        end else if (crc == want) begin
            r.crc_matches = 1'b1;
            r.verdict     = VERDICT_MATCH;
        end else begin
            r.crc_matches = 1'b0;
            r.verdict     = VERDICT_MISMATCH;
        end
        return r;
    endfunction

    // Advance the mirrored record state by one accepted request; flag a verdict if one is due.
    task automatic predict_request(input in_item_t it, output bit fires, output result_t res);
        logic [LENGTH_BITS-1:0] len;
        fires = 1'b0;
        res   = '0;
        if (it.op == OP_HEADER) begin
            len         = it.payload_length[LENGTH_BITS-1:0];
            crc_acc     = CRC_ONES;
            crc_on_file = it.expected_crc;
            if (len == 0) begin
                // Empty payload: judge at once against a CRC of zero, no inode rule.
                rec_open     = 1'b0;
                bytes_to_go  = '0;
                covered_left = '0;
                length_wrong = 1'b0;
                fires        = 1'b1;
                res          = grade(1'b0, '0, it.expected_crc);
            end else begin
                bytes_to_go = len;
                if (it.record_type == inode_code) begin
                    length_wrong = (len != inode_req);
                    covered_left = (inode_cov < len) ? inode_cov : len;
                end else begin
                    length_wrong = 1'b0;
                    covered_left = len;
                end
                rec_open = 1'b1;
            end
        end else if (rec_open) begin
            if (covered_left != 0) begin
                crc_acc = crc32_byte(crc_acc, it.payload_byte);
                covered_left--;
            end
            bytes_to_go--;
            if (bytes_to_go == 0) begin
                rec_open = 1'b0;
                fires    = 1'b1;
                res      = grade(length_wrong, ~crc_acc, crc_on_file);
            end
        end
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("%0t ns  MISMATCH  %s", $time, msg);
    endtask

    function automatic void add_row(op_t op, logic [TYPE_W-1:0] rtype, logic [LEN_FIELD_W-1:0] len,
                                    logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b, bit typed = 1'b0,
                                    bit good = 1'b0, verdict_t v = VERDICT_MATCH);
        stim_row_t r;
        r.item.op             = op;
        r.item.record_type    = rtype;
        r.item.payload_length = len;
        r.item.expected_crc   = crc;
        r.item.payload_byte   = b;
        r.typed               = typed;
        r.want.crc_matches    = good;
        r.want.verdict        = v;
        stim_rows.push_back(r);
    endfunction

    function automatic stim_row_t header_row(logic [TYPE_W-1:0] rtype, logic [LEN_FIELD_W-1:0] len,
                                             logic [CRC_W-1:0] crc);
        stim_row_t r;
        r.item.op             = OP_HEADER;
        r.item.record_type    = rtype;
        r.item.payload_length = len;
        r.item.expected_crc   = crc;
        r.item.payload_byte   = BYTE_W'($urandom);
        r.typed               = 1'b0;
        r.want                = '0;
        return r;
    endfunction

    // Scramble the header fields on data requests: the block must ignore them.
    function automatic stim_row_t data_row(logic [BYTE_W-1:0] b);
        stim_row_t r;
        r.item.op             = OP_DATA;
        r.item.record_type    = TYPE_W'($urandom);
        r.item.payload_length = LEN_FIELD_W'($urandom);
        r.item.expected_crc   = CRC_W'($urandom);
        r.item.payload_byte   = b;
        r.typed               = 1'b0;
        r.want                = '0;
        return r;
    endfunction

    // Offer one request, hold it until taken, then predict its verdict.
    // Keep s_valid high across back-to-back requests; drop it only for a gap.
    task automatic send_request(input stim_row_t row);
        int      gap;
        bit      fires;
        bit      was_open;
        result_t res;
        gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= row.item;
        do @(posedge aclk); while (!s_ready);
        was_open = rec_open;
        predict_request(row.item, fires, res);
        // Stray bytes with no record open are dropped by the block; do not count them.
        if (row.item.op == OP_HEADER || was_open)
            requests_counted++;
        if (row.item.op == OP_HEADER)
            records_started++;
        if (fires)
            verdicts_due.push_back(row.typed ? row.want : res);
    endtask

    // Drop valid, wait for every pending verdict, then let the queue run dry.
    task automatic settle();
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (HOLD_OFF) @(posedge aclk);
    endtask

    // Write all three inode registers back to back, then release the write enable.
    task automatic program_rule(input rule_set_t r);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INODE_TYPE;
        cfg_wdata <= r.type_word;
        @(posedge aclk);
        inode_code = r.type_word[TYPE_W-1:0];
        cfg_index <= CFG_INODE_REQ_LEN;
        cfg_wdata <= r.req_word;
        @(posedge aclk);
        inode_req = r.req_word[LENGTH_BITS-1:0];
        cfg_index <= CFG_INODE_COV_LEN;
        cfg_wdata <= r.cov_word;
        @(posedge aclk);
        inode_cov = r.cov_word[LENGTH_BITS-1:0];
        cfg_we <= 1'b0;
        @(posedge aclk);
        rule_sets++;
    endtask

    // One burst of traffic: mostly complete records, some cut short, some stray bytes.
    task automatic send_random_traffic();
        int               pick;
        int               len;
        int               covered;
        bit               to_inode;
        logic [TYPE_W-1:0] rtype;
        logic [CRC_W-1:0] crc;
        logic [CRC_W-1:0] stored;
        logic [BYTE_W-1:0] body[$];
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            to_inode = $urandom_range(0, 1);
            rtype    = to_inode ? inode_code : TYPE_W'($urandom);
            if (to_inode && inode_req <= 128 && $urandom_range(0, 1))
                len = inode_req;
            else if ($urandom_range(0, 19) == 0)
                len = $urandom_range(13, 64);
            else
                len = $urandom_range(0, 12);
            for (int n = 0; n < len; n++)
                body.push_back(BYTE_W'($urandom));
            // Build the good CRC so that most records can match.
            covered = (rtype == inode_code && inode_cov < len) ? int'(inode_cov) : len;
            crc = CRC_ONES;
            for (int n = 0; n < covered; n++)
                crc = crc32_byte(crc, body[n]);
            crc = (len == 0) ? '0 : ~crc;
            case ($urandom_range(0, 3))
                0, 1: stored = crc;
                2: stored = crc ^ (CRC_W'(1) << $urandom_range(0, CRC_W-1));
                default: stored = CRC_W'($urandom);
            endcase
            send_request(header_row(rtype, LEN_FIELD_W'(len), stored));
            foreach (body[n])
                send_request(data_row(body[n]));
        end else if (pick < 85) begin
            // Cut the record short; the next header abandons it.
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, (1 << LENGTH_BITS) - 1)
                                              : $urandom_range(2, 12);
            rtype = $urandom_range(0, 1) ? inode_code : TYPE_W'($urandom);
            send_request(header_row(rtype, LEN_FIELD_W'(len), CRC_W'($urandom)));
            repeat ($urandom_range(0, (len < 4) ? len - 1 : 3))
                send_request(data_row(BYTE_W'($urandom)));
        end else begin
            repeat ($urandom_range(1, 3))
                send_request(data_row(BYTE_W'($urandom)));
        end
    endtask

    // Run random traffic, reshuffling the idling pattern every chunk, then close
    // any open record with an empty header and drain.
    task automatic run_random(input int target);
        int goal;
        int next_shift;
        goal       = requests_counted + target;
        next_shift = requests_counted;
        while (requests_counted < goal) begin
            if (requests_counted >= next_shift) begin
                next_shift = requests_counted + CHUNK;
                {take_stalls_on, send_gaps_on} = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0)
                    settle();
            end
            send_random_traffic();
        end
        send_request(header_row(TYPE_W'($urandom), '0,
                                $urandom_range(0, 1) ? '0 : CRC_W'($urandom)));
        settle();
    endtask

    // Receiver: draw a stall for every verdict, then take it.
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = take_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare every taken verdict with the oldest one predicted.
    always @(posedge aclk) begin
        result_t due;
        if (aresetn && m_valid && m_ready) begin
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
                flag_error($sformatf("verdict %0d, crc_matches %0d with no record pending",
                                     m_data.verdict, m_data.crc_matches));
            end else begin
                due = verdicts_due.pop_front();
                if (m_data.crc_matches !== due.crc_matches)
                    flag_error($sformatf("crc_matches %0d, want %0d (verdict #%0d)",
                                         m_data.crc_matches, due.crc_matches, verdicts_seen));
                if (m_data.verdict !== due.verdict)
                    flag_error($sformatf("verdict %0d, want %0d (verdict #%0d)",
                                         m_data.verdict, due.verdict, verdicts_seen));
            end
        end
    end

    // Watchdog: end the run if neither channel moves a request for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        rule_set_t rules[4];
        // Low extremes: inode type 0, an inode record must be empty, nothing covered.
        rules[0] = '{'0, '0, '0, 150};
        // High extremes: write all ones, so the type register must drop the upper bits.
        rules[1] = '{'1, '1, '1, 150};
        // Short inode records with only the first three bytes covered.
        rules[2] = '{CFG_DATA_W'($urandom), CFG_DATA_W'(6), CFG_DATA_W'(3), 250};
        // Coverage longer than the required length: clip to the payload.
        rules[3] = '{CFG_DATA_W'($urandom), CFG_DATA_W'(10), CFG_DATA_W'(40), 250};

        // Directed table, run under the reset rule (inode type 1, lengths 128).
        add_row(OP_HEADER, 16'd5, '0, 32'h0000_0000, 8'h00, 1'b1, 1'b1, VERDICT_MATCH);
        add_row(OP_HEADER, 16'd1, '0, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0, VERDICT_MISMATCH);
        add_row(OP_DATA, 16'hFFFF, '1, 32'hFFFF_FFFF, 8'hA5);    // stray byte, no record
        // Standard check string "123456789" gives CBF43926.
        add_row(OP_HEADER, 16'd7, 20'd9, 32'hCBF4_3926, 8'h00);
        for (int k = 1; k <= 9; k++)
            add_row(OP_DATA, '0, '0, '0, BYTE_W'(8'h30 + k), k == 9, 1'b1, VERDICT_MATCH);
        // Inode record of the wrong length: length error regardless of CRC.
        add_row(OP_HEADER, 16'd1, 20'd2, 32'h0000_0000, 8'h5A);
        add_row(OP_DATA, 16'd1, 20'd2, '0, 8'h00);
        add_row(OP_DATA, 16'd1, 20'd2, '0, 8'hFF, 1'b1, 1'b0, VERDICT_LENGTH_BAD);
        // Longest record, abandoned by the next header.
        add_row(OP_HEADER, 16'hFFFF, '1, 32'hDEAD_BEEF, 8'h00);
        add_row(OP_DATA, '0, '0, '0, 8'h3C);
        add_row(OP_HEADER, 16'h8000, 20'd1, 32'h0000_0000, 8'hFF);
        add_row(OP_DATA, '1, '1, '1, 8'h00);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        {take_stalls_on, send_gaps_on} = 2'($urandom_range(0, 3));
        foreach (stim_rows[i])
            send_request(stim_rows[i]);
        // Hold the sender until every verdict is back.
        settle();
        run_random(200);
        foreach (rules[i]) begin
            program_rule(rules[i]);
            run_random(rules[i].requests);
        end

        $display("run covered %0d requests in %0d records under %0d inode rule settings",
                 requests_counted, records_started, rule_sets);
        $display("%0d verdicts compared, %0d mismatches", verdicts_seen, error_count);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

/* files.f */
rtl/core/lpcc_pkg.sv
rtl/core/lpcc_cmd_queue.sv
rtl/core/lpcc_front.sv
rtl/core/lpcc_back.sv
rtl/core/leaf_payload_crc_check.sv
dv/testbench.sv
